@@ design/pcrmv_pkg.sv @@
// Package for the per-column running mean and variance block.
// Holds the sequencer state type, the statistics record and fixed widths.
// No dependencies.
package pcrmv_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned ColW    = 6;
  localparam int unsigned SampleW = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned M2W     = 64;
  localparam int unsigned CfgW    = 7;

  // One radix-2 step per quotient bit of the 33-bit delta magnitude
  localparam int unsigned DivSteps = SampleW + 1;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_MEAN,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  // Packed so that the count sits in the lowest bits
  typedef struct packed {
    logic [M2W-1:0]     m2;
    logic [SampleW-1:0] mean;
    logic [CountW-1:0]  count;
  } stats_t;

endpackage

@@ design/per_column_running_mean_variance.sv @@
// Per-column running mean and variance (Welford update), top level.
// Holds the statistics memory, the sequencer and the shared radix-2 divider.
// Depends on pcrmv_pkg.
//
// Each input transfer names a column and carries a signed Q16.16 sample with a
// present flag in tuser. A present sample updates the column's count, mean and
// sum of squared deviations (Q32.32); an absent one only reads them. Either
// way one result transfer returns the column's statistics after the item.
// A column at or above column_count (or at or above COLUMNS) returns zeros
// with index_error set and leaves the memory alone. A present item occupies the
// block from its transfer to the next possible one: the idle cycle, one memory
// read, one load step, the restoring divider that forms delta / count, then the
// mean, product, accumulate and write-back steps. An absent item goes from its
// load step and an out-of-range item from idle straight to write-back. After
// reset the block clears every column of its memory, one column per cycle,
// before accepting any item; column_count writes are taken at any time. A finished
// result waits in an output register, so the next item is accepted while it is
// still pending; that item then holds in its write-back step until the
// register is free.
module per_column_running_mean_variance #(
  parameter int unsigned COLUMNS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: column_count
  input  logic                          cfg_wr_en_i,
  input  logic [pcrmv_pkg::CfgW-1:0]    cfg_wr_data_i,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,  // column, sample_value, pad
  input  logic                          s_axis_tuser,  // sample_present
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [127:0]                  m_axis_tdata,  // sample_count, running_mean,
                                                       // squared_deviation_sum
  output logic                          m_axis_tuser   // index_error
);
  import pcrmv_pkg::*;

  localparam int unsigned IdxW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(COLUMNS - 1);

  // Sequencer and item registers
  state_e               state_q, state_d;
  logic [IdxW-1:0]      clr_cnt_q;
  logic [ColW-1:0]      col_q;
  logic [SampleW-1:0]   x_q;
  logic                 pres_q;
  logic                 err_q;
  logic [CfgW-1:0]      cfg_q;

  // Datapath registers
  stats_t               stats_q;
  logic [SampleW:0]     delta_mag_q;
  logic                 neg_q;
  logic [SampleW:0]     dvd_q;     // dividend, becomes the quotient
  logic [CountW-1:0]    rem_q;
  logic [DivCntW-1:0]   div_cnt_q;
  logic [SampleW:0]     rest_mag_q;
  logic [M2W-1:0]       prod_q;

  // Output register
  logic                 out_valid_q;
  stats_t               out_data_q;
  logic                 out_err_q;

  // Memory
  stats_t               mem [COLUMNS];
  stats_t               rd_data_q;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_addr;
  stats_t               mem_wdata;

  logic                 in_xfer;
  logic                 in_range;
  logic                 out_free;

  // Combinational datapath values
  logic [SampleW:0]     delta;
  logic [CountW-1:0]    n_inc;
  logic [CountW:0]      div_sh;
  logic                 div_ge;
  logic [CountW:0]      div_diff;
  logic [SampleW:0]     quo;
  logic [SampleW:0]     new_mean;
  logic [SampleW:0]     rest;
  logic [2*SampleW+1:0] prod_full;
  logic [M2W:0]         m2_sum;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Column must be below both the register and the memory depth
  assign in_range = (CfgW'(s_axis_tdata[ColW-1:0]) < cfg_q) &&
                    (32'(s_axis_tdata[ColW-1:0]) < 32'(COLUMNS));

  // Arithmetic shared across the sequence
  always_comb begin
    delta     = {x_q[SampleW-1], x_q} - {rd_data_q.mean[SampleW-1], rd_data_q.mean};
    n_inc     = (rd_data_q.count == '1) ? rd_data_q.count : rd_data_q.count + 1'b1;
    div_sh    = {rem_q, dvd_q[SampleW]};
    div_diff  = div_sh - {1'b0, stats_q.count};
    div_ge    = !div_diff[CountW];
    quo       = dvd_q;
    new_mean  = neg_q ? ({stats_q.mean[SampleW-1], stats_q.mean} - quo)
                      : ({stats_q.mean[SampleW-1], stats_q.mean} + quo);
    rest      = {x_q[SampleW-1], x_q} - new_mean;
    prod_full = delta_mag_q * rest_mag_q;
    m2_sum    = {1'b0, stats_q.m2} + {1'b0, prod_q};
  end

  // Sequencer: next state and handshake
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = IdxW'(col_q);
    mem_wdata     = stats_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = '0;
        if (clr_cnt_q == LastIdx) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = in_range ? ST_READ : ST_DONE;
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = pres_q ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if (div_cnt_q == DivCntW'(DivSteps - 1)) state_d = ST_MEAN;
      end
      ST_MEAN: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          mem_we  = !err_q && pres_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      cfg_q     <= CfgW'(64);
      err_q     <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) cfg_q <= cfg_wr_data_i;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (in_xfer) err_q <= !in_range;
      if (state_q == ST_DIV) div_cnt_q <= div_cnt_q + 1'b1;
      else                   div_cnt_q <= '0;
    end
  end

  // Item capture and datapath steps
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      col_q  <= s_axis_tdata[ColW-1:0];
      x_q    <= s_axis_tdata[ColW+SampleW-1:ColW];
      pres_q <= s_axis_tuser;
    end
    case (state_q)
      ST_LOAD: begin
        // a present sample advances the count, an absent one keeps it
        stats_q     <= {rd_data_q.m2, rd_data_q.mean,
                        (pres_q ? n_inc : rd_data_q.count)};
        neg_q       <= delta[SampleW];
        delta_mag_q <= delta[SampleW] ? -delta : delta;
        dvd_q       <= delta[SampleW] ? -delta : delta;
        rem_q       <= '0;
      end
      ST_DIV: begin
        // One restoring step: shift in the next dividend bit, subtract if it fits
        rem_q <= div_ge ? div_diff[CountW-1:0] : div_sh[CountW-1:0];
        dvd_q <= {dvd_q[SampleW-1:0], div_ge};
      end
      ST_MEAN: begin
        stats_q.mean <= new_mean[SampleW-1:0];
        rest_mag_q   <= rest[SampleW] ? -rest : rest;
      end
      ST_MUL: prod_q <= prod_full[M2W-1:0];
      ST_ACC: stats_q.m2 <= m2_sum[M2W] ? '1 : m2_sum[M2W-1:0];
      default: ;
    endcase
  end

  // Statistics memory: one write port, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data_q <= mem[IdxW'(col_q)];
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= err_q ? '0 : stats_q;
      out_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

`ifndef SYNTH
  // Only an idle sequencer takes a new item
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_IDLE)
    else $error("input ready outside idle");

  // An accepted item closes the input until its result is formed
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while busy");

  // Divider never runs past its last step
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_cnt_q < DivCntW'(DivSteps))
    else $error("divider step count overrun");

  // A flagged result carries zero statistics
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == '0)
    else $error("flagged result with non-zero statistics");

  // Memory is written only while clearing or on completion of a present item
  a_mem_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR) || (state_q == ST_DONE && pres_q && !err_q))
    else $error("unexpected memory write");
`endif

endmodule

@@ tb/column_stats_checker.sv @@
`timescale 1ns / 100ps
// Checker for the per-column running mean and variance block: watches the
// configuration port and both streams, predicts each result and compares it.
// Depends on pcrmv_pkg.
module column_stats_checker #(
  parameter int unsigned COLUMNS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [pcrmv_pkg::CfgW-1:0] cfg_wr_data_i,
  input  logic                       in_tvalid_i,
  input  logic                       in_tready_i,
  input  logic [39:0]                in_tdata_i,  // column, sample_value, pad
  input  logic                       in_tuser_i,  // sample_present
  input  logic                       out_tvalid_i,
  input  logic                       out_tready_i,
  input  logic [127:0]               out_tdata_i, // sample_count, running_mean, m2
  input  logic                       out_tuser_i, // index_error
  output int                         fail_count_o,
  output int                         pending_o
);
  import pcrmv_pkg::*;

  typedef struct packed {
    stats_t stats;
    logic   index_error;
  } column_result_t;

  // Shadow copy of the statistics memory and the column_count register
  logic [CountW-1:0]         col_count [COLUMNS];
  logic signed [SampleW-1:0] col_mean  [COLUMNS];
  logic [M2W-1:0]            col_m2    [COLUMNS];
  logic [CfgW-1:0]           columns_in_use;

  column_result_t expected_stats_q[$];

  // Apply one sample to the shadow memory and return the column's statistics
  function automatic column_result_t update_column(input logic [ColW-1:0] col,
                                                   input logic signed [SampleW-1:0] x,
                                                   input logic present);
    logic signed [33:0] delta;
    logic signed [33:0] new_mean;
    logic signed [33:0] remain;
    logic [32:0]        delta_mag;
    logic [32:0]        remain_mag;
    logic [32:0]        step;
    logic [CountW-1:0]  n;
    logic [65:0]        product;
    logic [64:0]        total;
    column_result_t     res;
    res = '0;
    if (col >= columns_in_use || col >= COLUMNS) begin
      res.index_error = 1'b1;
      return res;
    end
    if (present) begin
      delta     = 34'(x) - 34'(col_mean[col]);
      delta_mag = (delta < 0) ? 33'(-delta) : 33'(delta);
      n = col_count[col];
      // the count sticks at all ones but still divides
      if (n != '1) n = n + 1'b1;
      step = delta_mag / n;
      if (delta < 0) new_mean = 34'(col_mean[col]) - $signed({1'b0, step});
      else           new_mean = 34'(col_mean[col]) + $signed({1'b0, step});
      remain     = 34'(x) - new_mean;
      remain_mag = (remain < 0) ? 33'(-remain) : 33'(remain);
      product    = 66'(delta_mag) * 66'(remain_mag);
      total      = 65'(col_m2[col]) + 65'(product[63:0]);
      col_m2[col]    = total[64] ? '1 : total[63:0];
      col_count[col] = n;
      col_mean[col]  = new_mean[SampleW-1:0];
    end
    res.stats.count = col_count[col];
    res.stats.mean  = col_mean[col];
    res.stats.m2    = col_m2[col];
    return res;
  endfunction

  function automatic void compare_field(input string field, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", field, exp_val, act_val);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    column_result_t want;
    stats_t         got;
    if (!rst_ni) begin
      for (int i = 0; i < COLUMNS; i++) begin
        col_count[i] = '0;
        col_mean[i]  = '0;
        col_m2[i]    = '0;
      end
      columns_in_use = CfgW'(64);
      expected_stats_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_wr_en_i) columns_in_use = cfg_wr_data_i;
      // retire the oldest expectation on each result transfer
      if (out_tvalid_i && out_tready_i) begin
        if (expected_stats_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          fail_count_o++;
        end else begin
          want = expected_stats_q.pop_front();
          got  = out_tdata_i;
          compare_field("sample_count", 64'(want.stats.count), 64'(got.count));
          compare_field("running_mean", 64'(want.stats.mean), 64'(got.mean));
          compare_field("squared_deviation_sum", want.stats.m2, got.m2);
          compare_field("index_error", 64'(want.index_error), 64'(out_tuser_i));
        end
      end
      if (in_tvalid_i && in_tready_i)
        expected_stats_q.push_back(update_column(in_tdata_i[ColW-1:0],
                                                 in_tdata_i[ColW+SampleW-1:ColW],
                                                 in_tuser_i));
    end
    pending_o = expected_stats_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the testbench for per_column_running_mean_variance: clock, reset,
// stimulus and verdict. Depends on pcrmv_pkg and column_stats_checker.
module testbench;
  import pcrmv_pkg::*;

  // Watchdog limit on the whole run of about 1550 items plus stalls and gaps,
  // with a wide margin.
  localparam int unsigned CycleLimit = 1_000_000;
  // Settle for a good margin at the end
  localparam int unsigned SettleCycles = 100;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CfgW-1:0]   cfg_wr_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [39:0]       s_tdata = '0;   // column, sample_value, pad
  logic              s_tuser = 1'b0; // sample_present
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [127:0]      m_tdata;        // sample_count, running_mean, m2
  logic              m_tuser;        // index_error

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  int cycle_count = 0;
  int fail_count;
  int pending_results;

  always #5 clk_i = ~clk_i;

  per_column_running_mean_variance #(
    .COLUMNS(64)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_wr_data_i(cfg_wr_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  column_stats_checker #(
    .COLUMNS(64)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_wr_data_i(cfg_wr_data),
    .in_tvalid_i  (s_tvalid),
    .in_tready_i  (s_tready),
    .in_tdata_i   (s_tdata),
    .in_tuser_i   (s_tuser),
    .out_tvalid_i (m_tvalid),
    .out_tready_i (m_tready),
    .out_tdata_i  (m_tdata),
    .out_tuser_i  (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // Watchdog: end the run if it hangs anywhere
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[per_column_running_mean_variance] ERROR");
      $finish;
    end
  end

  // Result side: a long hold-off, when requested, overrides the random stalls
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      m_tready <= 1'b0;
      hold_off_cycles--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one sample and hold it until the transfer; returns at a falling edge.
  // tvalid stays high into the next call unless that call idles first.
  task automatic send_sample(input logic [ColW-1:0] col, input logic [SampleW-1:0] x,
                             input logic present);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, x, col};
    s_tuser  <= present;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop tvalid and hold the sender until every result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  task automatic write_column_count(input logic [CfgW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk_i);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly present samples on columns in use, so that the statistics build up;
  // some out-of-range columns and read-only items are mixed in.
  task automatic send_random_sample(input int cols_in_use);
    logic [ColW-1:0]    col;
    logic [SampleW-1:0] x;
    logic [23:0]        moderate;
    logic               present;
    if (cols_in_use == 0 || $urandom_range(99) < 12) col = ColW'($urandom_range(63));
    else col = ColW'($urandom_range((cols_in_use > 64) ? 63 : cols_in_use - 1));
    moderate = 24'($urandom());
    case ($urandom_range(9))
      0:       x = 32'h7FFF_FFFF;
      1:       x = 32'h8000_0000;
      2, 3:    x = $urandom();
      default: x = {{8{moderate[23]}}, moderate};
    endcase
    present = ($urandom_range(99) < 85);
    send_sample(col, x, present);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: column_count at its reset value of 64
    send_sample(6'd0, 32'h0000_0000, 1'b0);   // read an empty column
    send_sample(6'd0, 32'h7FFF_FFFF, 1'b1);   // first sample: mean takes x
    // swing between the extremes so that m2 grows fast and saturates
    for (int i = 0; i < 8; i++)
      send_sample(6'd0, i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 1'b1);
    send_sample(6'd0, 32'hFFFF_FFFF, 1'b0);
    send_sample(6'd63, 32'hFFFF_FFFF, 1'b1);
    send_sample(6'd63, 32'h0001_0000, 1'b1);
    send_sample(6'd63, 32'h0000_0000, 1'b0);
    // A saturated count needs 2^32 samples in one column; out of reach here.
    drain_results();

    // One column in use: everything above column 0 is flagged
    write_column_count(CfgW'(1));
    send_sample(6'd0, 32'hFFFF_0000, 1'b1);
    send_sample(6'd1, 32'h1234_5678, 1'b1);
    send_sample(6'd63, 32'h1234_5678, 1'b0);
    drain_results();

    // No columns in use: every column is flagged
    write_column_count(CfgW'(0));
    send_sample(6'd0, 32'h0000_0001, 1'b1);
    send_sample(6'd0, 32'h0000_0001, 1'b0);
    drain_results();

    // Register beyond the column range
    write_column_count(CfgW'(127));
    send_sample(6'd63, 32'h8000_0000, 1'b1);
    send_sample(6'd62, 32'h5555_AAAA, 1'b1);
    drain_results();

    // Phase one: few columns so the counts grow large; sender idles little,
    // receiver a lot. Includes a long receiver hold-off to back up the block.
    write_column_count(CfgW'(8));
    send_idle_pct = 17;
    recv_idle_pct = 54;
    for (int i = 0; i < 200; i++) send_random_sample(8);
    hold_off_cycles = 400;
    for (int i = 0; i < 30; i++) send_random_sample(8);
    // pause the sender until the backlog has gone
    drain_results();
    for (int i = 0; i < 270; i++) send_random_sample(8);
    drain_results();

    // Phase two: all columns, roles of the two sides swapped
    write_column_count(CfgW'(64));
    send_idle_pct = 54;
    recv_idle_pct = 17;
    for (int i = 0; i < 500; i++) send_random_sample(64);
    drain_results();

    // Phase three: no idling, first a single column, then a random count
    write_column_count(CfgW'(1));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 250; i++) send_random_sample(1);
    drain_results();
    begin
      int cols;
      cols = $urandom_range(2, 63);
      write_column_count(CfgW'(cols));
      for (int i = 0; i < 250; i++) send_random_sample(cols);
    end
    drain_results();

    repeat (SettleCycles) @(negedge clk_i);
    if (pending_results != 0)
      $error("%0d results never arrived", pending_results);
    if (fail_count == 0 && pending_results == 0) begin
      $display("[per_column_running_mean_variance] OK");
    end else begin
      $display("[per_column_running_mean_variance] ERROR");
    end
    $finish;
  end

endmodule
